### design/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared types and constants for the normalized quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qsl_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;

  localparam logic [14:0] ONE_F = 15'd16384;
  localparam logic [30:0] ONE30 = 31'h4000_0000;

  localparam logic signed [CORDIC_W-1:0] HALF_PI30     = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN30 = 34'sd652032874;

  // arctangent of 2^-i, Q.30, truncated
  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2
  };

  // configuration register indexes
  localparam logic REG_LINEAR_THRESHOLD = 1'b0;
  localparam logic REG_NORM_TOLERANCE   = 1'b1;

  typedef logic signed [15:0] comp_t;
  typedef comp_t [3:0]        quat_t;
  typedef logic signed [25:0] rcomp_t;
  typedef rcomp_t [3:0]       rvec_t;

  typedef struct packed {
    quat_t       a;
    quat_t       b;
    logic [14:0] t;
    logic        lin;
    logic        flip;
    logic [30:0] cs;
  } front_t;

  typedef struct packed {
    quat_t       a;
    quat_t       b;
    logic [14:0] t;
    logic        lin;
    logic        flip;
    logic [1:0]  ovf;
  } mid_t;

  typedef struct packed {
    rvec_t r;
    logic  ident;
  } norm_t;

  typedef struct packed {
    logic [3:0] neg;
    logic [3:0] ovf;
    logic       ident;
  } fin_t;

endpackage

### design/qsl_pair_if.sv
// ----------------------------------------------------------------------------
// qsl_pair_if
// Input channel: two quaternions and a blend fraction.
// ----------------------------------------------------------------------------
interface qsl_pair_if;
  import qsl_pkg::*;

  logic        valid;
  logic        ready;
  comp_t       a_x;
  comp_t       a_y;
  comp_t       a_z;
  comp_t       a_w;
  comp_t       b_x;
  comp_t       b_y;
  comp_t       b_z;
  comp_t       b_w;
  logic [14:0] blend;

  modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                output ready);
endinterface

### design/qsl_result_if.sv
// ----------------------------------------------------------------------------
// qsl_result_if
// Output channel: normalized result quaternion.
// ----------------------------------------------------------------------------
interface qsl_result_if;
  import qsl_pkg::*;

  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

### design/qsl_isqrt.sv
// ----------------------------------------------------------------------------
// qsl_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qsl_isqrt #(
  parameter int IN_W  = 62,
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     rad,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [TAG_W-1:0]    out_tag
);
  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 4;

  logic             vld   [RW];
  logic [REM_W-1:0] rem_q [RW];
  logic [RW-1:0]    rt_q  [RW];
  logic [IN_W-1:0]  src_q [RW];
  logic [TAG_W-1:0] tag_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic             p_vld;
    logic [REM_W-1:0] p_rem;
    logic [RW-1:0]    p_rt;
    logic [IN_W-1:0]  p_src;
    logic [TAG_W-1:0] p_tag;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = '0;
      assign p_rt  = '0;
      assign p_src = rad;
      assign p_tag = in_tag;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_rem = rem_q[k-1];
      assign p_rt  = rt_q[k-1];
      assign p_src = src_q[k-1];
      assign p_tag = tag_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {p_rem[REM_W-3:0], p_src[IN_W-1 -: 2]};
    assign trial = {{(REM_W-RW-2){1'b0}}, p_rt, 2'b01};
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
      if (en) begin
        rem_q[k] <= fit ? cur - trial : cur;
        rt_q[k]  <= {p_rt[RW-2:0], fit};
        src_q[k] <= {p_src[IN_W-3:0], 2'b00};
        tag_q[k] <= p_tag;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt_q[RW-1];
  assign out_tag   = tag_q[RW-1];
endmodule

### design/qsl_cordic.sv
// ----------------------------------------------------------------------------
// qsl_cordic
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation.
// ----------------------------------------------------------------------------
module qsl_cordic #(
  parameter int LANES = 1,
  parameter int TAG_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic                                 vec,
  input  logic signed [qsl_pkg::CORDIC_W-1:0]  x0 [LANES],
  input  logic signed [qsl_pkg::CORDIC_W-1:0]  y0 [LANES],
  input  logic signed [qsl_pkg::CORDIC_W-1:0]  z0 [LANES],
  input  logic [TAG_W-1:0]                     in_tag,
  output logic                                 out_valid,
  output logic signed [qsl_pkg::CORDIC_W-1:0]  y_out [LANES],
  output logic signed [qsl_pkg::CORDIC_W-1:0]  z_out [LANES],
  output logic [TAG_W-1:0]                     out_tag
);
  import qsl_pkg::*;

  logic                       vld   [CORDIC_STEPS];
  logic                       mode  [CORDIC_STEPS];
  logic [TAG_W-1:0]           tag_q [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_q   [CORDIC_STEPS][LANES];
  logic signed [CORDIC_W-1:0] y_q   [CORDIC_STEPS][LANES];
  logic signed [CORDIC_W-1:0] z_q   [CORDIC_STEPS][LANES];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    localparam logic signed [CORDIC_W-1:0] ANG = CORDIC_W'(ATAN_TAB[k]);
    logic             p_vld;
    logic             p_vec;
    logic [TAG_W-1:0] p_tag;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_vec = vec;
      assign p_tag = in_tag;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_vec = mode[k-1];
      assign p_tag = tag_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
      if (en) begin
        mode[k]  <= p_vec;
        tag_q[k] <= p_tag;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CORDIC_W-1:0] p_x;
      logic signed [CORDIC_W-1:0] p_y;
      logic signed [CORDIC_W-1:0] p_z;
      logic                       pos;

      if (k == 0) begin : g_first
        assign p_x = x0[l];
        assign p_y = y0[l];
        assign p_z = z0[l];
      end else begin : g_next
        assign p_x = x_q[k-1][l];
        assign p_y = y_q[k-1][l];
        assign p_z = z_q[k-1][l];
      end

      // vectoring drives y toward zero, rotation drives z toward zero
      assign pos = p_vec ? (p_y[CORDIC_W-1] || p_y == '0) : !p_z[CORDIC_W-1];

      always_ff @(posedge clk) begin
        if (en) begin
          x_q[k][l] <= pos ? p_x - (p_y >>> k) : p_x + (p_y >>> k);
          y_q[k][l] <= pos ? p_y + (p_x >>> k) : p_y - (p_x >>> k);
          z_q[k][l] <= pos ? p_z - ANG : p_z + ANG;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign y_out[l] = y_q[CORDIC_STEPS-1][l];
    assign z_out[l] = z_q[CORDIC_STEPS-1][l];
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign out_tag   = tag_q[CORDIC_STEPS-1];
endmodule

### design/qsl_div.sv
// ----------------------------------------------------------------------------
// qsl_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module qsl_div #(
  parameter int LANES = 1,
  parameter int D_W   = 32,
  parameter int Q_W   = 17,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [D_W-1:0]   den,
  input  logic [D_W-1:0]   rem0 [LANES],
  input  logic [Q_W-1:0]   low  [LANES],
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo  [LANES],
  output logic [TAG_W-1:0] out_tag
);
  logic             vld   [Q_W];
  logic [D_W-1:0]   den_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];
  logic [D_W-1:0]   rem_q [Q_W][LANES];
  logic [Q_W-1:0]   low_q [Q_W][LANES];
  logic [Q_W-1:0]   quo_q [Q_W][LANES];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             p_vld;
    logic [D_W-1:0]   p_den;
    logic [TAG_W-1:0] p_tag;

    if (k == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_den = den;
      assign p_tag = in_tag;
    end else begin : g_next
      assign p_vld = vld[k-1];
      assign p_den = den_q[k-1];
      assign p_tag = tag_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
      if (en) begin
        den_q[k] <= p_den;
        tag_q[k] <= p_tag;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [D_W-1:0] p_rem;
      logic [Q_W-1:0] p_low;
      logic [Q_W-1:0] p_quo;
      logic [D_W:0]   cur;
      logic [D_W:0]   diff;
      logic           fit;

      if (k == 0) begin : g_first
        assign p_rem = rem0[l];
        assign p_low = low[l];
        assign p_quo = '0;
      end else begin : g_next
        assign p_rem = rem_q[k-1][l];
        assign p_low = low_q[k-1][l];
        assign p_quo = quo_q[k-1][l];
      end

      assign cur  = {p_rem, p_low[Q_W-1]};
      assign diff = cur - {1'b0, p_den};
      assign fit  = cur >= {1'b0, p_den};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][l] <= fit ? diff[D_W-1:0] : cur[D_W-1:0];
          low_q[k][l] <= {p_low[Q_W-2:0], 1'b0};
          quo_q[k][l] <= {p_quo[Q_W-2:0], fit};
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = quo_q[Q_W-1][l];
  end

  assign out_valid = vld[Q_W-1];
  assign out_tag   = tag_q[Q_W-1];
endmodule

### design/quat_slerp_normalized_unit.sv
// ----------------------------------------------------------------------------
// quat_slerp_normalized_unit
// Normalized shortest-arc quaternion slerp, fully pipelined, Q2.14 in and out.
// ----------------------------------------------------------------------------
//   channel   | dir | handshake          | contents
//   pair      | in  | valid/ready        | a_x..a_w, b_x..b_w, blend
//   result    | out | valid/ready        | out_x..out_w
//   apb       | in  | psel/penable/pready| linear_threshold @0, norm_tolerance @4
//
// One item per cycle enters and leaves while the output is not held. The
// path runs through the root (31), angle CORDIC (30), sine CORDIC (30),
// weight divider (31), length root (32) and output divider (17) pipelines,
// nine arithmetic stages and the output register.
// rst is synchronous and empties the pipeline; the registers return to 16382
// and 3. When the output is held, the whole pipeline holds with it.
// ----------------------------------------------------------------------------
module quat_slerp_normalized_unit (
  input  logic         clk,
  input  logic         rst,
  qsl_pair_if.sink     pair,
  qsl_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import qsl_pkg::*;

  // ---------------- configuration ----------------
  logic [14:0] linear_threshold;
  logic [29:0] norm_tolerance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_threshold <= 15'd16382;
      norm_tolerance   <= 30'd3;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LINEAR_THRESHOLD: linear_threshold <= pwdata[14:0];
        REG_NORM_TOLERANCE:   norm_tolerance   <= pwdata[29:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINEAR_THRESHOLD: prdata = 32'(linear_threshold);
      REG_NORM_TOLERANCE:   prdata = 32'(norm_tolerance);
      default:              prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic en;
  logic out_valid;

  assign en          = !out_valid || result.ready;
  assign pair.ready  = en;

  // ---------------- S1: dot products ----------------
  quat_t       a_in, b_in;
  logic        v1;
  logic signed [31:0] prod1 [4];
  quat_t       a1, b1;
  logic [14:0] t1;

  assign a_in = {pair.a_w, pair.a_z, pair.a_y, pair.a_x};
  assign b_in = {pair.b_w, pair.b_z, pair.b_y, pair.b_x};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= pair.valid && pair.ready;
    if (en) begin
      for (int i = 0; i < 4; i++) prod1[i] <= a_in[i] * b_in[i];
      a1 <= a_in;
      b1 <= b_in;
      t1 <= (pair.blend > ONE_F) ? ONE_F : pair.blend;
    end
  end

  // ---------------- S2: cosine, arc select ----------------
  logic signed [33:0] dot;
  logic [33:0]        mag;
  logic               v2, lin2, flip2;
  logic [30:0]        c2;
  quat_t              a2, b2;
  logic [14:0]        t2;

  assign dot = 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]) + 34'(prod1[3]);
  assign mag = dot[33] ? -dot : dot;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      flip2 <= dot[33];
      lin2  <= mag >= {5'd0, linear_threshold, 14'd0};
      c2    <= (mag >= 34'd268435456) ? ONE30 : {mag[28:0], 2'b00};
      a2    <= a1;
      b2    <= b1;
      t2    <= t1;
    end
  end

  // ---------------- S3: cosine squared ----------------
  logic        v3;
  logic [61:0] csq3;
  front_t      f3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      csq3 <= 62'(c2) * 62'(c2);
      f3   <= '{a: a2, b: b2, t: t2, lin: lin2, flip: flip2, cs: c2};
    end
  end

  // ---------------- sine of the angle ----------------
  logic                       v4;
  logic [30:0]                s4;
  logic [$bits(front_t)-1:0]  f4_raw;
  front_t                     f4, f4v;

  qsl_isqrt #(.IN_W(62), .TAG_W($bits(front_t))) u_sin_root (
    .clk, .rst, .en,
    .in_valid  (v3),
    .rad       ({2'b01, 60'd0} - csq3),
    .in_tag    (f3),
    .out_valid (v4),
    .root      (s4),
    .out_tag   (f4_raw)
  );

  always_comb begin
    f4      = front_t'(f4_raw);
    f4v     = f4;
    f4v.lin = f4.lin || (s4 == '0);
    f4v.cs  = s4;
  end

  // ---------------- angle ----------------
  logic signed [CORDIC_W-1:0] vx0 [1], vy0 [1], vz0 [1], vz [1];
  logic                       v5;
  logic [$bits(front_t)-1:0]  f5_raw;
  front_t                     f5;
  logic [30:0]                om;

  assign vx0[0] = CORDIC_W'(f4.cs);
  assign vy0[0] = CORDIC_W'(s4);
  assign vz0[0] = '0;

  qsl_cordic #(.LANES(1), .TAG_W($bits(front_t))) u_angle (
    .clk, .rst, .en,
    .in_valid  (v4),
    .vec       (1'b1),
    .x0        (vx0),
    .y0        (vy0),
    .z0        (vz0),
    .in_tag    (f4v),
    .out_valid (v5),
    .y_out     (),
    .z_out     (vz),
    .out_tag   (f5_raw)
  );

  assign f5 = front_t'(f5_raw);
  assign om = vz[0][CORDIC_W-1] ? 31'd0 :
              (vz[0] > HALF_PI30) ? HALF_PI30[30:0] : vz[0][30:0];

  // ---------------- S6: partial angles ----------------
  logic        v6;
  logic [30:0] th0, th1;
  front_t      f6;
  logic [45:0] thp0, thp1;

  assign thp0 = 46'(om) * 46'(ONE_F - f5.t);
  assign thp1 = 46'(om) * 46'(f5.t);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      th0 <= thp0[44:14];
      th1 <= thp1[44:14];
      f6  <= f5;
    end
  end

  // ---------------- sines of the partial angles ----------------
  logic signed [CORDIC_W-1:0] rx0 [2], ry0 [2], rz0 [2], ry [2];
  logic                       v7;
  logic [$bits(front_t)-1:0]  f7_raw;
  front_t                     f7;
  logic [30:0]                sn [2];
  logic [30:0]                dv_rem [2];
  logic [30:0]                dv_low [2];
  mid_t                       m7;

  for (genvar l = 0; l < 2; l++) begin : g_rot_in
    assign rx0[l] = CORDIC_GAIN30;
    assign ry0[l] = '0;
  end
  assign rz0[0] = CORDIC_W'(th0);
  assign rz0[1] = CORDIC_W'(th1);

  qsl_cordic #(.LANES(2), .TAG_W($bits(front_t))) u_sine (
    .clk, .rst, .en,
    .in_valid  (v6),
    .vec       (1'b0),
    .x0        (rx0),
    .y0        (ry0),
    .z0        (rz0),
    .in_tag    (f6),
    .out_valid (v7),
    .y_out     (ry),
    .z_out     (),
    .out_tag   (f7_raw)
  );

  assign f7 = front_t'(f7_raw);

  always_comb begin
    m7 = '{a: f7.a, b: f7.b, t: f7.t, lin: f7.lin, flip: f7.flip, ovf: 2'b00};
    for (int l = 0; l < 2; l++) begin
      sn[l] = ry[l][CORDIC_W-1] ? 31'd0 :
              (ry[l] > CORDIC_W'(ONE30)) ? ONE30 : ry[l][30:0];
      // quotient of sn*2^30/s reaches 2^31 when sn >= 2s
      m7.ovf[l]  = {1'b0, sn[l]} >= {f7.cs, 1'b0};
      dv_rem[l]  = {1'b0, sn[l][30:1]};
      dv_low[l]  = {sn[l][0], 30'd0};
    end
  end

  // ---------------- weight division ----------------
  logic                    v8;
  logic [30:0]             wq [2];
  logic [$bits(mid_t)-1:0] m8_raw;
  mid_t                    m8;

  qsl_div #(.LANES(2), .D_W(31), .Q_W(31), .TAG_W($bits(mid_t))) u_weight_div (
    .clk, .rst, .en,
    .in_valid  (v7),
    .den       (f7.cs),
    .rem0      (dv_rem),
    .low       (dv_low),
    .in_tag    (m7),
    .out_valid (v8),
    .quo       (wq),
    .out_tag   (m8_raw)
  );

  assign m8 = mid_t'(m8_raw);

  // ---------------- S9: weights ----------------
  logic        v9, flip9;
  logic [30:0] w0_9, w1_9;
  quat_t       a9, b9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      if (m8.lin) begin
        w0_9 <= {ONE_F - m8.t, 16'd0};
        w1_9 <= {m8.t, 16'd0};
      end else begin
        w0_9 <= (m8.ovf[0] || wq[0] > ONE30) ? ONE30 : wq[0];
        w1_9 <= (m8.ovf[1] || wq[1] > ONE30) ? ONE30 : wq[1];
      end
      flip9 <= m8.flip;
      a9    <= m8.a;
      b9    <= m8.b;
    end
  end

  // ---------------- S10: weighted components ----------------
  logic               v10, flip10;
  logic signed [47:0] pa10 [4], pb10 [4];

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pa10[i] <= 48'($signed({1'b0, w0_9}) * a9[i]);
        pb10[i] <= 48'($signed({1'b0, w1_9}) * b9[i]);
      end
      flip10 <= flip9;
    end
  end

  // ---------------- S11: blend and round ----------------
  logic               v11;
  rvec_t              r11;
  logic signed [48:0] bsum [4];
  logic [48:0]        babs [4];
  logic [26:0]        bmag [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bsum[i] = flip10 ? 49'(pa10[i]) - 49'(pb10[i]) : 49'(pa10[i]) + 49'(pb10[i]);
      babs[i] = bsum[i][48] ? 49'(-bsum[i]) : 49'(bsum[i]);
      bmag[i] = 27'((babs[i] + 49'd2097152) >> 22);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r11[i] <= bsum[i][48] ? -rcomp_t'(bmag[i][25:0]) : rcomp_t'(bmag[i][25:0]);
      end
    end
  end

  // ---------------- S12: squares ----------------
  logic               v12;
  rvec_t              r12;
  logic [49:0]        sq12 [4];
  logic signed [51:0] sqp  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) sqp[i] = r11[i] * r11[i];
  end

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
    if (en) begin
      for (int i = 0; i < 4; i++) sq12[i] <= sqp[i][49:0];
      r12 <= r11;
    end
  end

  // ---------------- S13: squared length, tolerance ----------------
  logic        v13;
  logic [50:0] qsum, q13;
  norm_t       n13;

  assign qsum = 51'(sq12[0]) + 51'(sq12[1]) + 51'(sq12[2]) + 51'(sq12[3]);

  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (en) v13 <= v12;
    if (en) begin
      q13       <= qsum;
      n13.r     <= r12;
      n13.ident <= (qsum == '0) || (qsum < {5'd0, norm_tolerance, 16'd0});
    end
  end

  // ---------------- length ----------------
  logic                     v14;
  logic [31:0]              nlen;
  logic [$bits(norm_t)-1:0] n14_raw;
  norm_t                    n14;

  qsl_isqrt #(.IN_W(64), .TAG_W($bits(norm_t))) u_len_root (
    .clk, .rst, .en,
    .in_valid  (v13),
    .rad       ({1'b0, q13, 12'd0}),
    .in_tag    (n13),
    .out_valid (v14),
    .root      (nlen),
    .out_tag   (n14_raw)
  );

  assign n14 = norm_t'(n14_raw);

  // ---------------- output division ----------------
  logic [25:0] rmag [4];
  logic [46:0] num  [4];
  logic [31:0] od_rem [4];
  logic [16:0] od_low [4];
  fin_t        fi14;

  always_comb begin
    fi14.ident = n14.ident;
    for (int i = 0; i < 4; i++) begin
      rmag[i]     = n14.r[i][25] ? 26'(-n14.r[i]) : 26'(n14.r[i]);
      num[i]      = {1'b0, rmag[i], 20'd0} + 47'(nlen >> 1);
      fi14.neg[i] = n14.r[i][25];
      // quotient needs more than 17 bits
      fi14.ovf[i] = {2'b00, num[i]} >= {nlen, 17'd0};
      od_rem[i]   = 32'(num[i][46:17]);
      od_low[i]   = num[i][16:0];
    end
  end

  logic                    v15;
  logic [16:0]             oq [4];
  logic [$bits(fin_t)-1:0] fi15_raw;
  fin_t                    fi15;

  qsl_div #(.LANES(4), .D_W(32), .Q_W(17), .TAG_W($bits(fin_t))) u_norm_div (
    .clk, .rst, .en,
    .in_valid  (v14),
    .den       (nlen),
    .rem0      (od_rem),
    .low       (od_low),
    .in_tag    (fi14),
    .out_valid (v15),
    .quo       (oq),
    .out_tag   (fi15_raw)
  );

  assign fi15 = fin_t'(fi15_raw);

  // ---------------- output register ----------------
  comp_t comp_next [4];
  comp_t comp_q    [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fi15.ident) begin
        comp_next[i] = (i == 3) ? comp_t'({1'b0, ONE_F}) : '0;
      end else if (fi15.neg[i]) begin
        comp_next[i] = (fi15.ovf[i] || oq[i] >= 17'd32768) ? 16'sh8000 :
                       -comp_t'(oq[i][15:0]);
      end else begin
        comp_next[i] = (fi15.ovf[i] || oq[i] >= 17'd32767) ? 16'sh7fff :
                       comp_t'(oq[i][15:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v15;
    if (en) begin
      for (int i = 0; i < 4; i++) comp_q[i] <= comp_next[i];
    end
  end

  assign result.valid = out_valid;
  assign result.out_x = comp_q[0];
  assign result.out_y = comp_q[1];
  assign result.out_z = comp_q[2];
  assign result.out_w = comp_q[3];
endmodule
